// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property checked on every edge outside of reset
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// property checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/dpmf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dpmf_pkg;

  // default sizes
  localparam int unsigned DEF_PRIO_DEPTH  = 8;
  localparam int unsigned DEF_LOCAL_DEPTH = 32;
  localparam int unsigned DEF_ITEM_W      = 64;

  // fixed field widths
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned PAYLOAD_W   = 64;
  localparam int unsigned PCOUNT_W    = 3;
  localparam int unsigned LCOUNT_W    = 5;
  localparam int unsigned OUT_TDATA_W = PAYLOAD_W + PCOUNT_W + LCOUNT_W;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_PRIO  = 2'd0,
    CMD_PUSH_LOCAL = 2'd1,
    CMD_POP        = 2'd2
  } command_e;

  // ring status seen by the control logic
  typedef struct packed {
    logic full;
    logic empty;
  } ring_status_t;

  // per-beat flags, also the layout of the result tuser (lowest bit last)
  typedef struct packed {
    logic dropped;
    logic from_priority;
    logic item_valid;
  } result_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dpmf_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dpmf_ring #(
  parameter int unsigned DEPTH   = dpmf_pkg::DEF_PRIO_DEPTH,
  parameter int unsigned WIDTH   = dpmf_pkg::DEF_ITEM_W,
  parameter int unsigned PTR_W   = $clog2(DEPTH)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire logic                   pop_i,
  input  wire logic [WIDTH-1:0]       wdata_i,
  output dpmf_pkg::ring_status_t      status_o,
  output logic      [PTR_W-1:0]       count_o,
  output logic      [WIDTH-1:0]       rdata_o
);

  import dpmf_pkg::*;

  logic [PTR_W-1:0] head_q, head_d, head_nxt;
  logic [PTR_W-1:0] tail_q, tail_d, tail_nxt;
  logic [PTR_W:0]   diff;
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // pointer increment with wrap at the ring depth
  assign head_nxt = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
  assign tail_nxt = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);

  // one slot stays empty, so full means head is one behind tail
  assign status_o.full  = (head_nxt == tail_q);
  assign status_o.empty = (head_q == tail_q);

  // occupancy
  always_comb begin
    if (head_q >= tail_q) begin
      diff = {1'b0, head_q} - {1'b0, tail_q};
    end else begin
      diff = {1'b0, head_q} + (PTR_W + 1)'(DEPTH) - {1'b0, tail_q};
    end
  end
  assign count_o = diff[PTR_W-1:0];

  assign head_d = push_i ? head_nxt : head_q;
  assign tail_d = pop_i ? tail_nxt : tail_q;

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  // storage: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[head_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      rdata_q <= mem_q[tail_q];
    end
  end

  assign rdata_o = rdata_q;

  `ASSERT_RST(a_push_not_full, clk_i, rst_ni, push_i |-> !status_o.full)
  `ASSERT_RST(a_pop_not_empty, clk_i, rst_ni, pop_i |-> !status_o.empty)
  `ASSERT_RST(a_full_empty_excl, clk_i, rst_ni, !(status_o.full && status_o.empty))

endmodule

`default_nettype wire

// ===== hw/rtl/dual_priority_message_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// a taken command beat passes the ring stage, then the result register, before its result beat is offered
// throughput: one command beat per cycle unless m_axis_tready stalls a full pipeline
// the next command may enter while a result waits if the ring stage is empty, the result register parts the two sides
// reset clears ring pointers and pipeline valid flags; ring storage is not cleared

module dual_priority_message_fifo #(
  parameter int unsigned PRIORITY_DEPTH = dpmf_pkg::DEF_PRIO_DEPTH,
  parameter int unsigned LOCAL_DEPTH    = dpmf_pkg::DEF_LOCAL_DEPTH,
  parameter int unsigned ITEM_WIDTH     = dpmf_pkg::DEF_ITEM_W
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [dpmf_pkg::PAYLOAD_W-1:0]     s_axis_tdata,  // payload[63:0]
  input  wire logic [dpmf_pkg::CMD_W-1:0]         s_axis_tuser,  // command[1:0]
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // item_data[63:0], priority_count[66:64], local_count[71:67]
  output logic      [dpmf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // item_valid[0], from_priority[1], dropped[2]
  output dpmf_pkg::result_flags_t                 m_axis_tuser
);

  import dpmf_pkg::*;

  localparam int unsigned PPTR_W = $clog2(PRIORITY_DEPTH);
  localparam int unsigned LPTR_W = $clog2(LOCAL_DEPTH);

  command_e              cmd;
  logic                  s_fire;
  logic                  out_ready;
  logic                  prio_push, prio_pop, local_push, local_pop;
  ring_status_t          prio_st, local_st;
  logic [PPTR_W-1:0]     prio_cnt;
  logic [LPTR_W-1:0]     local_cnt;
  logic [ITEM_WIDTH-1:0] prio_rdata, local_rdata, item_w;
  logic [31:0]           prio_cnt_ext, local_cnt_ext;
  result_flags_t         flags_d, flags_q;
  logic                  s1_valid_q;
  logic                  out_valid_q;
  result_flags_t         out_flags_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // handshake: result register, then the ring stage
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || out_ready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cmd           = command_e'(s_axis_tuser);

  // command decode against ring status
  always_comb begin
    prio_push  = 1'b0;
    prio_pop   = 1'b0;
    local_push = 1'b0;
    local_pop  = 1'b0;
    flags_d    = '0;
    if (s_fire) begin
      unique case (cmd)
        CMD_PUSH_PRIO: begin
          if (prio_st.full) flags_d.dropped = 1'b1;
          else              prio_push = 1'b1;
        end
        CMD_PUSH_LOCAL: begin
          if (local_st.full) flags_d.dropped = 1'b1;
          else               local_push = 1'b1;
        end
        CMD_POP: begin
          if (!prio_st.empty) begin
            prio_pop              = 1'b1;
            flags_d.item_valid    = 1'b1;
            flags_d.from_priority = 1'b1;
          end else if (!local_st.empty) begin
            local_pop          = 1'b1;
            flags_d.item_valid = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  dpmf_ring #(
    .DEPTH (PRIORITY_DEPTH),
    .WIDTH (ITEM_WIDTH)
  ) u_prio_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (prio_push),
    .pop_i    (prio_pop),
    .wdata_i  (s_axis_tdata[ITEM_WIDTH-1:0]),
    .status_o (prio_st),
    .count_o  (prio_cnt),
    .rdata_o  (prio_rdata)
  );

  dpmf_ring #(
    .DEPTH (LOCAL_DEPTH),
    .WIDTH (ITEM_WIDTH)
  ) u_local_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (local_push),
    .pop_i    (local_pop),
    .wdata_i  (s_axis_tdata[ITEM_WIDTH-1:0]),
    .status_o (local_st),
    .count_o  (local_cnt),
    .rdata_o  (local_rdata)
  );

  // ring stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      flags_q <= flags_d;
    end
  end

  // result beat assembly: ring read data and post-step counts
  always_comb begin
    if (!flags_q.item_valid)        item_w = '0;
    else if (flags_q.from_priority) item_w = prio_rdata;
    else                            item_w = local_rdata;
  end
  assign prio_cnt_ext  = 32'(prio_cnt);
  assign local_cnt_ext = 32'(local_cnt);
  assign out_data_d = {local_cnt_ext[LCOUNT_W-1:0], prio_cnt_ext[PCOUNT_W-1:0],
                       PAYLOAD_W'(item_w)};

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      out_flags_q <= flags_q;
      out_data_q  <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_flags_q;

  `ASSERT_RST(a_accept_fills_stage, clk_i, rst_ni, s_fire |=> s1_valid_q)
  `ASSERT_RST(a_idle_stage_ready, clk_i, rst_ni, !s1_valid_q |-> s_axis_tready)
  `ASSERT_RST(a_prio_needs_item, clk_i, rst_ni,
              m_axis_tvalid |-> (!m_axis_tuser.from_priority || m_axis_tuser.item_valid))
  `ASSERT_RST(a_drop_not_pop, clk_i, rst_ni,
              m_axis_tvalid |-> !(m_axis_tuser.dropped && m_axis_tuser.item_valid))

endmodule

`default_nettype wire
